// ===== rtl/topological_sort_cycle_check_defines.svh =====
// Assertion macros shared by the topological sort RTL.
`ifndef TOPOLOGICAL_SORT_CYCLE_CHECK_DEFINES_SVH
`define TOPOLOGICAL_SORT_CYCLE_CHECK_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TSC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle, outside reset.
`define TSC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tsc_pkg.sv =====
// Package with sizes, types and state codes of the topological sort block.
package tsc_pkg;

    localparam int MAX_NODES = 32;
    localparam int MAX_EDGES = 256;

    // Node index and node count widths (fixed by the item fields)
    localparam int NODE_W = 5;
    localparam int NCNT_W = 6;

    // Edge store address and edge count / in-degree widths
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_INIT,
        ST_POP,
        ST_EMIT,
        ST_ECHK,
        ST_EUPD,
        ST_STATUS
    } state_t;

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    // Request bundle toward the in-degree store
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [ECNT_W-1:0] wr_data;
        logic              clear;
    } indeg_req_t;

endpackage

// ===== rtl/tsc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; a read of the entry being written gets old data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/tsc_indeg.sv =====
// In-degree store: RAM plus per-node valid bits so a clear needs no RAM writes.
module tsc_indeg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tsc_pkg::indeg_req_t        req,
    output logic [tsc_pkg::ECNT_W-1:0] rd_value
);

    logic [tsc_pkg::MAX_NODES-1:0] vbit_reg;
    logic [tsc_pkg::MAX_NODES-1:0] vbit_next;
    logic                          vld_q_reg;
    logic [tsc_pkg::ECNT_W-1:0]    ram_rd_data;

    tsc_ram #(
        .WIDTH(tsc_pkg::ECNT_W),
        .DEPTH(tsc_pkg::MAX_NODES)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (req.wr_en),
        .wr_addr(req.wr_addr),
        .wr_data(req.wr_data),
        .rd_en  (req.rd_en),
        .rd_addr(req.rd_addr),
        .rd_data(ram_rd_data)
    );

    // Mark written entries; drop all marks on clear
    always_comb begin
        vbit_next = vbit_reg;
        if (req.clear) begin
            vbit_next = '0;
        end else if (req.wr_en) begin
            vbit_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vbit_reg  <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            vbit_reg <= vbit_next;
            if (req.rd_en) begin
                vld_q_reg <= vbit_reg[req.rd_addr];
            end
        end
    end

    // An entry never written since the last clear reads as zero
    assign rd_value = vld_q_reg ? ram_rd_data : '0;

endmodule

// ===== rtl/topological_sort_cycle_check.sv =====
// Top level: edge loading, Kahn sort sequencer and result output register.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser=op, s_tdata={dst,src}
//  m_      | out | m_tvalid/m_tready  | m_tuser=is_status, m_tdata, m_tlast=last
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data=node_count
//
// Edge loads are accepted back to back.
// A run scans the N nodes and queues those of in-degree zero (N = effective node
// count), then emits each queued node and walks every stored edge, with one more
// step per edge leaving that node; the edge store RAM read port sets this pace.
// A last pop and the status beat close the run; the graph is then empty again.
// Reset is synchronous and active low; a full output register holds the sequencer.
module topological_sort_cycle_check (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [4:0] src_node, [9:5] dst_node, [15:10] zero
    input  logic [15:0] s_tdata,
    // s_tuser: [0] op
    input  logic [0:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [4:0] node_id, [5] cycle_found, [11:6] emitted_total,
    //          [12] edges_dropped, [15:13] zero
    output logic [15:0] m_tdata,
    // m_tuser: [0] is_status
    output logic [0:0]  m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

`include "topological_sort_cycle_check_defines.svh"

    localparam int NW = tsc_pkg::NODE_W;
    localparam int CW = tsc_pkg::NCNT_W;
    localparam int EW = tsc_pkg::ECNT_W;
    localparam int AW = tsc_pkg::EDGE_AW;

    tsc_pkg::state_t state_reg, state_next;

    logic [CW-1:0] node_count_reg;
    logic [CW-1:0] n_eff;
    logic [EW-1:0] edge_total_reg, edge_total_next;
    logic          drop_reg, drop_next;

    // Load increment stage and one-deep forwarding of its last write
    logic          ld_valid_reg, ld_valid_next;
    logic [NW-1:0] ld_dst_reg;
    logic          fw_valid_reg;
    logic [NW-1:0] fw_addr_reg;
    logic [EW-1:0] fw_data_reg;
    logic [EW-1:0] ld_deg;

    // Seeding scan
    logic [CW-1:0] idx_reg, idx_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [NW-1:0] chk_node_reg;

    // Queue pointers and counters
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [CW-1:0] emitted_reg, emitted_next;

    // Edge walk
    logic [NW-1:0] cur_node_reg, cur_node_next;
    logic [EW-1:0] e_idx_reg, e_idx_next;
    logic [EW-1:0] e_idx_inc;
    logic [NW-1:0] d_reg, d_next;

    // Output register
    logic          out_valid_reg;
    logic          out_load;
    logic          out_free;
    logic [NW-1:0] out_node_next;
    logic          out_status_next;
    logic          out_cycle_next;
    logic [CW-1:0] out_total_next;
    logic          out_drop_next;
    logic [NW-1:0] out_node_reg;
    logic          out_status_reg;
    logic          out_cycle_reg;
    logic [CW-1:0] out_total_reg;
    logic          out_drop_reg;

    // Memory ports
    logic          e_wr_en;
    logic          e_rd_en;
    logic [AW-1:0] e_rd_addr;
    logic [2*NW-1:0] e_rd_data;
    logic          q_wr_en;
    logic [NW-1:0] q_wr_data;
    logic          q_rd_en;
    logic [NW-1:0] q_rd_data;

    tsc_pkg::indeg_req_t indeg_req;
    logic [EW-1:0]       indeg_rd;

    logic          s_beat;
    logic [NW-1:0] s_src;
    logic [NW-1:0] s_dst;
    logic          edge_ok;
    logic [NW-1:0] e_src;
    logic [NW-1:0] e_dst;

    assign s_src  = s_tdata[NW-1:0];
    assign s_dst  = s_tdata[2*NW-1:NW];
    assign s_beat = s_tvalid && s_tready;
    assign e_src  = e_rd_data[2*NW-1:NW];
    assign e_dst  = e_rd_data[NW-1:0];

    // Saturate the node count at the store size
    assign n_eff = (node_count_reg > CW'(tsc_pkg::MAX_NODES)) ?
                   CW'(tsc_pkg::MAX_NODES) : node_count_reg;

    assign edge_ok = (CW'(s_src) < n_eff) && (CW'(s_dst) < n_eff) &&
                     (edge_total_reg < EW'(tsc_pkg::MAX_EDGES));

    // Current in-degree for the load stage, forwarded from the previous write
    assign ld_deg = (fw_valid_reg && (fw_addr_reg == ld_dst_reg)) ? fw_data_reg : indeg_rd;

    assign e_idx_inc = e_idx_reg + EW'(1);
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == tsc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    tsc_ram #(
        .WIDTH(2 * NW),
        .DEPTH(tsc_pkg::MAX_EDGES)
    ) u_edge_ram (
        .aclk   (aclk),
        .wr_en  (e_wr_en),
        .wr_addr(edge_total_reg[AW-1:0]),
        .wr_data({s_src, s_dst}),
        .rd_en  (e_rd_en),
        .rd_addr(e_rd_addr),
        .rd_data(e_rd_data)
    );

    tsc_ram #(
        .WIDTH(NW),
        .DEPTH(tsc_pkg::MAX_NODES)
    ) u_queue_ram (
        .aclk   (aclk),
        .wr_en  (q_wr_en),
        .wr_addr(tail_reg[NW-1:0]),
        .wr_data(q_wr_data),
        .rd_en  (q_rd_en),
        .rd_addr(head_reg[NW-1:0]),
        .rd_data(q_rd_data)
    );

    tsc_indeg u_indeg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (indeg_req),
        .rd_value(indeg_rd)
    );

    // Sequencer: next state, memory requests and output loads
    always_comb begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        drop_next       = drop_reg;
        ld_valid_next   = 1'b0;
        idx_next        = idx_reg;
        chk_valid_next  = chk_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        emitted_next    = emitted_reg;
        cur_node_next   = cur_node_reg;
        e_idx_next      = e_idx_reg;
        d_next          = d_reg;
        e_wr_en         = 1'b0;
        e_rd_en         = 1'b0;
        e_rd_addr       = e_idx_reg[AW-1:0];
        q_wr_en         = 1'b0;
        q_wr_data       = chk_node_reg;
        q_rd_en         = 1'b0;
        out_load        = 1'b0;
        out_node_next   = q_rd_data;
        out_status_next = 1'b0;
        out_cycle_next  = 1'b0;
        out_total_next  = '0;
        out_drop_next   = 1'b0;
        indeg_req       = '0;

        // Finish a pending in-degree increment from a load
        if (ld_valid_reg) begin
            indeg_req.wr_en   = 1'b1;
            indeg_req.wr_addr = ld_dst_reg;
            indeg_req.wr_data = ld_deg + EW'(1);
        end

        unique case (state_reg)
            tsc_pkg::ST_IDLE: begin
                if (s_beat) begin
                    if (s_tuser[0] == tsc_pkg::OP_RUN) begin
                        state_next = tsc_pkg::ST_WAIT;
                    end else if (edge_ok) begin
                        e_wr_en           = 1'b1;
                        edge_total_next   = edge_total_reg + EW'(1);
                        indeg_req.rd_en   = 1'b1;
                        indeg_req.rd_addr = s_dst;
                        ld_valid_next     = 1'b1;
                    end else begin
                        drop_next = 1'b1;
                    end
                end
            end
            tsc_pkg::ST_WAIT: begin
                // Let the last load write land before seeding reads start
                idx_next       = '0;
                chk_valid_next = 1'b0;
                head_next      = '0;
                tail_next      = '0;
                emitted_next   = '0;
                state_next     = tsc_pkg::ST_INIT;
            end
            tsc_pkg::ST_INIT: begin
                // Queue the node checked last cycle if its in-degree is zero
                if (chk_valid_reg && (indeg_rd == '0) &&
                    (tail_reg < CW'(tsc_pkg::MAX_NODES))) begin
                    q_wr_en   = 1'b1;
                    tail_next = tail_reg + CW'(1);
                end
                if (idx_reg < n_eff) begin
                    indeg_req.rd_en   = 1'b1;
                    indeg_req.rd_addr = idx_reg[NW-1:0];
                    chk_valid_next    = 1'b1;
                    idx_next          = idx_reg + CW'(1);
                end else begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg) begin
                        state_next = tsc_pkg::ST_POP;
                    end
                end
            end
            tsc_pkg::ST_POP: begin
                if (head_reg == tail_reg) begin
                    state_next = tsc_pkg::ST_STATUS;
                end else begin
                    q_rd_en    = 1'b1;
                    state_next = tsc_pkg::ST_EMIT;
                end
            end
            tsc_pkg::ST_EMIT: begin
                // Emit the popped node and start its edge walk
                if (out_free) begin
                    out_load      = 1'b1;
                    cur_node_next = q_rd_data;
                    head_next     = head_reg + CW'(1);
                    emitted_next  = emitted_reg + CW'(1);
                    e_idx_next    = '0;
                    if (edge_total_reg == '0) begin
                        state_next = tsc_pkg::ST_POP;
                    end else begin
                        e_rd_en    = 1'b1;
                        e_rd_addr  = '0;
                        state_next = tsc_pkg::ST_ECHK;
                    end
                end
            end
            tsc_pkg::ST_ECHK: begin
                if (e_src == cur_node_reg) begin
                    indeg_req.rd_en   = 1'b1;
                    indeg_req.rd_addr = e_dst;
                    d_next            = e_dst;
                    state_next        = tsc_pkg::ST_EUPD;
                end else begin
                    e_idx_next = e_idx_inc;
                    if (e_idx_inc < edge_total_reg) begin
                        e_rd_en   = 1'b1;
                        e_rd_addr = e_idx_inc[AW-1:0];
                    end else begin
                        state_next = tsc_pkg::ST_POP;
                    end
                end
            end
            tsc_pkg::ST_EUPD: begin
                // Decrement the destination and queue it when it reaches zero
                if (indeg_rd != '0) begin
                    indeg_req.wr_en   = 1'b1;
                    indeg_req.wr_addr = d_reg;
                    indeg_req.wr_data = indeg_rd - EW'(1);
                    if ((indeg_rd == EW'(1)) && (tail_reg < CW'(tsc_pkg::MAX_NODES))) begin
                        q_wr_en   = 1'b1;
                        q_wr_data = d_reg;
                        tail_next = tail_reg + CW'(1);
                    end
                end
                e_idx_next = e_idx_inc;
                if (e_idx_inc < edge_total_reg) begin
                    e_rd_en    = 1'b1;
                    e_rd_addr  = e_idx_inc[AW-1:0];
                    state_next = tsc_pkg::ST_ECHK;
                end else begin
                    state_next = tsc_pkg::ST_POP;
                end
            end
            tsc_pkg::ST_STATUS: begin
                // Send the status beat and clear the graph
                if (out_free) begin
                    out_load        = 1'b1;
                    out_node_next   = '0;
                    out_status_next = 1'b1;
                    out_cycle_next  = (emitted_reg != n_eff);
                    out_total_next  = emitted_reg;
                    out_drop_next   = drop_reg;
                    indeg_req.clear = 1'b1;
                    edge_total_next = '0;
                    drop_next       = 1'b0;
                    head_next       = '0;
                    tail_next       = '0;
                    emitted_next    = '0;
                    state_next      = tsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tsc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tsc_pkg::ST_IDLE;
            node_count_reg <= CW'(tsc_pkg::MAX_NODES);
            edge_total_reg <= '0;
            drop_reg       <= 1'b0;
            ld_valid_reg   <= 1'b0;
            fw_valid_reg   <= 1'b0;
            idx_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            emitted_reg    <= '0;
            e_idx_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end
            edge_total_reg <= edge_total_next;
            drop_reg       <= drop_next;
            ld_valid_reg   <= ld_valid_next;
            fw_valid_reg   <= ld_valid_reg;
            idx_reg        <= idx_next;
            chk_valid_reg  <= chk_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            emitted_reg    <= emitted_next;
            e_idx_reg      <= e_idx_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ld_valid_next) begin
            ld_dst_reg <= s_dst;
        end
        fw_addr_reg  <= ld_dst_reg;
        fw_data_reg  <= indeg_req.wr_data;
        chk_node_reg <= idx_reg[NW-1:0];
        cur_node_reg <= cur_node_next;
        d_reg        <= d_next;
        if (out_load) begin
            out_node_reg   <= out_node_next;
            out_status_reg <= out_status_next;
            out_cycle_reg  <= out_cycle_next;
            out_total_reg  <= out_total_next;
            out_drop_reg   <= out_drop_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_drop_reg, out_total_reg, out_cycle_reg, out_node_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_status_reg;

    `TSC_ASSERT(a_queue_order, head_reg <= tail_reg, "queue head passed tail")
    `TSC_ASSERT(a_pop_count, emitted_reg == head_reg, "emitted count out of step with pops")
    `TSC_ASSERT_IMP(a_out_no_overwrite, out_load, (!out_valid_reg || m_tready),
        "output register loaded while holding an untaken beat")
    `TSC_ASSERT_IMP(a_load_only_idle, ld_valid_reg, (state_reg == tsc_pkg::ST_IDLE ||
        state_reg == tsc_pkg::ST_WAIT), "in-degree increment outside load phase")

endmodule

// ===== verif/topo_sort_checker.sv =====
// Checker for the topological sort block: predicts each run's node order and status beat.
module topo_sort_checker
    import tsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    output int          pending,
    output int          errors
);

    typedef struct packed {
        logic [4:0] node_id;
        logic       is_status;
        logic       cycle_found;
        logic [5:0] emitted_total;
        logic       edges_dropped;
        logic       last;
    } sort_beat_t;

    // Shadow of the block's graph state
    logic [5:0] node_cfg;
    logic [9:0] edge_mem [MAX_EDGES];
    int         edge_cnt;
    int         indeg [MAX_NODES];
    logic       drop_seen;
    int         err_total = 0;

    sort_beat_t order_q[$];

    // Append a predicted beat behind the older ones
    function automatic void queue_beat(input sort_beat_t nb);
        order_q = {order_q, nb};
    endfunction

    function automatic int live_nodes();
        return (node_cfg > MAX_NODES) ? MAX_NODES : int'(node_cfg);
    endfunction

    // Empty the graph; the node count survives
    task automatic clear_graph();
        edge_cnt  = 0;
        drop_seen = 1'b0;
        for (int i = 0; i < MAX_NODES; i++) indeg[i] = 0;
    endtask

    // Store an edge in arrival order, or flag it as dropped
    task automatic load_edge(input logic [4:0] src, input logic [4:0] dst);
        int n;
        n = live_nodes();
        if (src >= n || dst >= n || edge_cnt >= MAX_EDGES) begin
            drop_seen = 1'b1;
        end else begin
            edge_mem[edge_cnt] = {src, dst};
            edge_cnt++;
            indeg[dst]++;
        end
    endtask

    // Kahn pass: queue the roots, pop FIFO, release successors edge by edge
    task automatic run_sort();
        int         n;
        int         head;
        int         tail;
        int         emitted;
        int         d;
        logic [4:0] node;
        logic [4:0] fifo [MAX_NODES];
        sort_beat_t b;
        n       = live_nodes();
        head    = 0;
        tail    = 0;
        emitted = 0;
        for (int i = 0; i < n; i++) begin
            if (indeg[i] == 0) begin
                fifo[tail] = 5'(i);
                tail++;
            end
        end
        while (head < tail) begin
            node = fifo[head];
            head++;
            emitted++;
            b         = '0;
            b.node_id = node;
            queue_beat(b);
            for (int e = 0; e < edge_cnt; e++) begin
                d = edge_mem[e][4:0];
                if (edge_mem[e][9:5] == node && indeg[d] > 0) begin
                    indeg[d]--;
                    if (indeg[d] == 0 && tail < MAX_NODES) begin
                        fifo[tail] = 5'(d);
                        tail++;
                    end
                end
            end
        end
        b               = '0;
        b.is_status     = 1'b1;
        b.cycle_found   = (emitted != n);
        b.emitted_total = 6'(emitted);
        b.edges_dropped = drop_seen;
        b.last          = 1'b1;
        queue_beat(b);
        clear_graph();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_total++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // Compare one result beat against the oldest prediction
    task automatic check_beat();
        sort_beat_t want;
        if (order_q.size() == 0) begin
            err_total++;
            $display("%0t: result beat expected none got tdata %h tuser %b tlast %b",
                     $time, m_tdata, m_tuser, m_tlast);
            return;
        end
        want = order_q.pop_front();
        check_field("node_id", want.node_id, m_tdata[4:0]);
        check_field("is_status", want.is_status, m_tuser[0]);
        check_field("cycle_found", want.cycle_found, m_tdata[5]);
        check_field("emitted_total", want.emitted_total, m_tdata[11:6]);
        check_field("edges_dropped", want.edges_dropped, m_tdata[12]);
        check_field("last", want.last, m_tlast);
    endtask

    // Track config, input and result beats on each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            node_cfg = 6'd32;
            clear_graph();
            order_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) node_cfg = cfg_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_RUN) run_sort();
                else load_edge(s_tdata[4:0], s_tdata[9:5]);
            end
            if (m_tvalid && m_tready) check_beat();
        end
        pending <= order_q.size();
        errors  <= err_total;
    end

endmodule

// ===== verif/tb_topological_sort_cycle_check.sv =====
// Testbench top: drives edge loads, sort runs and node count writes, and gives the verdict.
module tb_topological_sort_cycle_check;
    import tsc_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 8;
    localparam int RAND_ITEMS = 65;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data  = '0;

    int sort_pending;
    int sort_errors;
    bit tx_quiet    = 1'b0;   // hold off sender gaps
    bit rx_quiet    = 1'b0;   // hold off receiver stalls
    int stall_left  = 0;
    int idle_cycles = 0;
    int node_lim    = 32;     // effective node count last written

    topological_sort_cycle_check dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    topo_sort_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pending   (sort_pending),
        .errors    (sort_errors)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls on the result channel
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!rx_quiet) stall_left <= gap_len();
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_topological_sort_cycle_check failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one input beat after a random gap; valid stays up for a following beat
    task automatic send_item(input logic op, input logic [4:0] src, input logic [4:0] dst);
        int gap;
        gap = tx_quiet ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, dst, src};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and let every predicted beat drain, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sort_pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_node_count(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= 6'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        node_lim = (value > MAX_NODES) ? MAX_NODES : value;
    endtask

    initial begin
        int         rand_items;
        int         n_edges;
        int         kind;
        int         a;
        int         b;
        int         off;
        int         r;
        int         value;
        logic [4:0] src;
        logic [4:0] dst;

        rand_items = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset count of 32: two-node cycle between the extreme indexes
        send_item(OP_ADD_EDGE, 5'd31, 5'd0);
        send_item(OP_ADD_EDGE, 5'd0, 5'd31);
        send_item(OP_RUN, 5'd31, 5'd31);
        wait_drained();

        // Zero nodes: every edge drops, the run gives the status beat alone
        set_node_count(0);
        send_item(OP_ADD_EDGE, 5'd0, 5'd0);
        send_item(OP_RUN, 5'd0, 5'd0);
        wait_drained();

        // Count above the node limit saturates: chain, far edge and a self loop
        set_node_count(63);
        send_item(OP_ADD_EDGE, 5'd1, 5'd2);
        send_item(OP_ADD_EDGE, 5'd2, 5'd3);
        send_item(OP_ADD_EDGE, 5'd0, 5'd1);
        send_item(OP_ADD_EDGE, 5'd31, 5'd30);
        send_item(OP_ADD_EDGE, 5'd7, 5'd7);
        send_item(OP_RUN, 5'd0, 5'd0);
        wait_drained();

        // Single node: bare run, then a self loop
        set_node_count(1);
        send_item(OP_RUN, 5'd0, 5'd0);
        send_item(OP_ADD_EDGE, 5'd0, 5'd0);
        send_item(OP_RUN, 5'd0, 5'd0);
        wait_drained();

        // Diamond with the count just past the limit
        set_node_count(33);
        send_item(OP_ADD_EDGE, 5'd3, 5'd1);
        send_item(OP_ADD_EDGE, 5'd3, 5'd2);
        send_item(OP_ADD_EDGE, 5'd1, 5'd0);
        send_item(OP_ADD_EDGE, 5'd2, 5'd0);
        send_item(OP_RUN, 5'd0, 5'd0);
        wait_drained();

        // Out-of-range source and destination beside a valid edge
        set_node_count(5);
        send_item(OP_ADD_EDGE, 5'd5, 5'd0);
        send_item(OP_ADD_EDGE, 5'd0, 5'd5);
        send_item(OP_ADD_EDGE, 5'd4, 5'd0);
        send_item(OP_RUN, 5'd0, 5'd0);
        wait_drained();

        // Store overflow: one edge repeated past the store depth
        set_node_count(2);
        tx_quiet = 1'b1;
        repeat (MAX_EDGES + 2) send_item(OP_ADD_EDGE, 5'd0, 5'd1);
        tx_quiet = 1'b0;
        send_item(OP_RUN, 5'd0, 5'd0);
        wait_drained();

        // Random graphs: mostly DAGs under a rotated labeling, plus back edges,
        // self loops and stray edges
        while (rand_items < RAND_ITEMS) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            if (rand_items == 0 || $urandom_range(0, 2) == 0) begin
                wait_drained();
                r = $urandom_range(0, 19);
                if (r == 0) value = 0;
                else if (r < 4) value = $urandom_range(33, 63);
                else value = $urandom_range(1, 32);
                set_node_count(value);
            end else if ($urandom_range(0, 1) == 0) begin
                wait_drained();
            end

            off     = (node_lim > 0) ? $urandom_range(0, node_lim - 1) : 0;
            n_edges = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(0, 16);
            repeat (n_edges) begin
                kind = $urandom_range(0, 99);
                if (node_lim >= 2 && kind < 78) begin
                    a = $urandom_range(0, node_lim - 2);
                    b = $urandom_range(a + 1, node_lim - 1);
                    if (kind < 70) begin
                        src = 5'((a + off) % node_lim);
                        dst = 5'((b + off) % node_lim);
                    end else begin
                        src = 5'((b + off) % node_lim);
                        dst = 5'((a + off) % node_lim);
                    end
                end else if (node_lim >= 1 && kind < 86) begin
                    src = 5'($urandom_range(0, node_lim - 1));
                    dst = src;
                end else begin
                    src = 5'($urandom_range(0, 31));
                    dst = 5'($urandom_range(0, 31));
                end
                send_item(OP_ADD_EDGE, src, dst);
                rand_items++;
            end
            send_item(OP_RUN, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            rand_items++;
        end

        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
        wait_drained();
        if (sort_errors == 0 && sort_pending == 0) begin
            $display("tb_topological_sort_cycle_check passed");
        end else begin
            $display("tb_topological_sort_cycle_check failed");
        end
        $finish;
    end

endmodule
